### rtl/core/rc_channel_normalizer_unit_defines.svh
// assertion macros for the rc channel normalizer
`ifndef RC_CHANNEL_NORMALIZER_UNIT_DEFINES_SVH
`define RC_CHANNEL_NORMALIZER_UNIT_DEFINES_SVH

// checked only out of reset
`define RCN_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("rcn assertion failed");

// checked at every edge, reset included
`define RCN_ASSERT_RST(name, expr) \
  name: assert property (@(posedge clk_i) (expr)) \
    else $error("rcn assertion failed");

`endif

### rtl/core/rcn_pkg.sv
// shared types and constants of the rc channel normalizer
package rcn_pkg;

  localparam int unsigned PW_W       = 16;
  localparam int unsigned SCALE_W    = 8;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIVD_W     = 24;
  localparam int unsigned QUOT_W     = 8;

  localparam logic [PW_W-1:0] RANGE_MIN_RST = 16'd1000;
  localparam logic [PW_W-1:0] RANGE_MAX_RST = 16'd2000;
  localparam logic [PW_W-1:0] HOLD_TOL      = 16'd2;

  localparam logic [DIVD_W-1:0] SCALE_GAIN = 24'd200;
  localparam logic [QUOT_W:0]   SCALE_OFS  = 9'd100;

  localparam logic signed [SCALE_W-1:0] SCALE_POS = 8'sd100;
  localparam logic signed [SCALE_W-1:0] SCALE_NEG = -8'sd100;
  localparam logic signed [SCALE_W-1:0] DEAD_HI   = 8'sd10;
  localparam logic signed [SCALE_W-1:0] DEAD_LO   = -8'sd10;
  localparam logic signed [SCALE_W-1:0] SCALE_ZERO = 8'sd0;

  localparam logic signed [DIR_W-1:0] DIR_POS  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_NEG  = 2'sb11;
  localparam logic signed [DIR_W-1:0] DIR_ZERO = 2'sb00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_MIN   = 2'd0,
    CFG_RANGE_MAX   = 2'd1,
    CFG_BINARY_MODE = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [PW_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic              rem_nz;
  } div_rsp_t;

endpackage

### rtl/core/rcn_in_if.sv
// input channel carrying one pulse width sample per beat
interface rcn_in_if;
  logic                      valid;
  logic                      ready;
  logic [rcn_pkg::PW_W-1:0]  pulse_width;

  modport source (output valid, output pulse_width, input ready);
  modport sink   (input valid, input pulse_width, output ready);
endinterface

### rtl/core/rcn_out_if.sv
// output channel carrying one normalized result per beat
interface rcn_out_if;
  logic                                valid;
  logic                                ready;
  logic                                accepted;
  logic                                changed;
  logic [rcn_pkg::PW_W-1:0]            held_value;
  logic signed [rcn_pkg::SCALE_W-1:0]  scaled;
  logic signed [rcn_pkg::DIR_W-1:0]    direction;
  logic                                switch_on;

  modport source (output valid, output accepted, output changed, output held_value,
                  output scaled, output direction, output switch_on, input ready);
  modport sink   (input valid, input accepted, input changed, input held_value,
                  input scaled, input direction, input switch_on, output ready);
endinterface

### rtl/core/rc_channel_normalizer_unit.sv
// top level of the rc channel normalizer
// the held value goes through the 24-step serial divider, except when it sits below the range
//   minimum, at or above the range maximum, or the range is empty; the result is then set directly
// throughput: one beat per result; no new beat is taken until the last result is registered;
//   the next beat is taken the cycle after the result is registered, even while it waits
// reset: async active low; ranges return to 1000..2000, held value and flag to zero
`include "rc_channel_normalizer_unit_defines.svh"

module rc_channel_normalizer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rcn_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rcn_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  rcn_in_if.sink                           in_i,
  rcn_out_if.source                        out_o
);
  import rcn_pkg::*;

  state_e state_q, state_d;

  logic [PW_W-1:0] range_min_q, range_max_q;
  logic            binary_q;
  logic [PW_W-1:0] held_q;
  logic            chg_q;
  logic            ok_q;
  logic signed [SCALE_W-1:0] res_q;

  logic                      out_valid_q;
  logic                      out_ok_q, out_chg_q, out_sw_q;
  logic [PW_W-1:0]           out_held_q;
  logic signed [SCALE_W-1:0] out_scaled_q;
  logic signed [DIR_W-1:0]   out_dir_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic            in_beat, out_load;
  logic            pw_ok;
  logic [PW_W-1:0] pw_diff;
  logic            empty_rng, below, above;
  logic [PW_W-1:0] offs;
  logic [QUOT_W:0] div_res;
  logic signed [SCALE_W-1:0] dz_res;

  assign in_beat  = in_i.valid && in_i.ready;
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  assign pw_ok   = (in_i.pulse_width >= range_min_q) && (in_i.pulse_width <= range_max_q);
  assign pw_diff = (in_i.pulse_width > held_q) ? in_i.pulse_width - held_q
                                               : held_q - in_i.pulse_width;

  assign empty_rng = range_max_q <= range_min_q;
  assign below     = held_q < range_min_q;
  assign above     = held_q >= range_max_q;
  assign offs      = held_q - range_min_q;

  assign div_req.start    = (state_q == ST_SETUP) && !empty_rng && !below && !above;
  assign div_req.dividend = DIVD_W'(offs) * SCALE_GAIN;
  assign div_req.divisor  = range_max_q - range_min_q;

  // ceil of the quotient below the midpoint gives truncation toward zero
  assign div_res = {1'b0, div_rsp.quot}
                 + ((div_rsp.quot >= QUOT_W'(SCALE_OFS)) ? '0 : (QUOT_W+1)'(div_rsp.rem_nz))
                 - SCALE_OFS;

  assign dz_res = (res_q > DEAD_LO && res_q < DEAD_HI) ? SCALE_ZERO : res_q;

  rcn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = ST_SETUP;
      ST_SETUP: state_d = div_req.start ? ST_DIV : ST_FIN;
      ST_DIV:   if (div_rsp.done) state_d = ST_FIN;
      ST_FIN:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      range_min_q <= RANGE_MIN_RST;
      range_max_q <= RANGE_MAX_RST;
      binary_q    <= 1'b0;
      held_q      <= '0;
      chg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_RANGE_MIN:   range_min_q <= cfg_data_i[PW_W-1:0];
          CFG_RANGE_MAX:   range_max_q <= cfg_data_i[PW_W-1:0];
          CFG_BINARY_MODE: binary_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_beat && pw_ok) begin
        if (pw_diff > HOLD_TOL) begin
          held_q <= in_i.pulse_width;
          chg_q  <= 1'b1;
        end else begin
          chg_q  <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      ok_q <= pw_ok;
    end
    if (state_q == ST_SETUP) begin
      if (empty_rng) begin
        res_q <= SCALE_ZERO;
      end else if (below) begin
        res_q <= SCALE_NEG;
      end else if (above) begin
        res_q <= SCALE_POS;
      end
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      res_q <= signed'(div_res[SCALE_W-1:0]);
    end
    if (out_load) begin
      out_ok_q     <= ok_q;
      out_chg_q    <= chg_q;
      out_held_q   <= held_q;
      out_scaled_q <= dz_res;
      out_dir_q    <= (dz_res > SCALE_ZERO) ? DIR_POS
                    : ((dz_res < SCALE_ZERO) ? DIR_NEG : DIR_ZERO);
      out_sw_q     <= binary_q && (held_q == range_max_q);
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.accepted   = out_ok_q;
  assign out_o.changed    = out_chg_q;
  assign out_o.held_value = out_held_q;
  assign out_o.scaled     = out_scaled_q;
  assign out_o.direction  = out_dir_q;
  assign out_o.switch_on  = out_sw_q;

  `RCN_ASSERT(a_beat_to_setup, in_beat |=> (state_q == ST_SETUP))
  `RCN_ASSERT(a_done_in_div, div_rsp.done |-> (state_q == ST_DIV))
  `RCN_ASSERT_RST(a_dir_sign, out_valid_q |-> ((out_scaled_q == SCALE_ZERO) == (out_dir_q == DIR_ZERO)))
  `RCN_ASSERT(a_scaled_range, out_valid_q |-> (out_scaled_q <= SCALE_POS && out_scaled_q >= SCALE_NEG))

endmodule

### rtl/core/rcn_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module rcn_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcn_pkg::div_req_t req_i,
  output rcn_pkg::div_rsp_t rsp_o
);
  import rcn_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVD_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVD_W-1:0] dq_q, dq_d;
  logic [PW_W-1:0]   rem_q, rem_d;
  logic [PW_W-1:0]   dsr_q, dsr_d;

  logic [PW_W:0]     trial;
  logic [PW_W:0]     diff;
  logic              ge;

  assign trial = {rem_q, dq_q[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dq_d  = {dq_q[DIVD_W-2:0], ge};
      rem_d = ge ? diff[PW_W-1:0] : trial[PW_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = dq_q[QUOT_W-1:0];
  assign rsp_o.rem_nz = |rem_q;

endmodule

### bench/testbench.sv
// self-checking testbench of the rc channel normalizer: predicted results against every output beat
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rcn_pkg::*;

  typedef struct {
    logic                      accepted;
    logic                      changed;
    logic [PW_W-1:0]           held_value;
    logic signed [SCALE_W-1:0] scaled;
    logic signed [DIR_W-1:0]   direction;
    logic                      switch_on;
  } norm_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rcn_in_if  in_if ();
  rcn_out_if out_if ();

  rc_channel_normalizer_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // predictor state and register copies
  logic [PW_W-1:0] rng_min  = RANGE_MIN_RST;
  logic [PW_W-1:0] rng_max  = RANGE_MAX_RST;
  logic            bin_mode = 1'b0;
  logic [PW_W-1:0] held_pw  = '0;
  logic            held_flag = 1'b0;

  logic [PW_W-1:0] pulse_q[$];
  norm_t           norm_q[$];
  norm_t           want;

  int  beats_queued  = 0;
  int  results_seen  = 0;
  int  mismatches    = 0;
  int  stall_requests = 0;
  int  stalls_served = 0;
  int  gap_left      = 0;
  int  hold_left     = 0;
  bit  in_took       = 1'b0;
  bit  calm          = 1'b0;
  logic [PW_W-1:0] last_pw = '0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [SCALE_W-1:0] scale_of(logic [PW_W-1:0] h);
    longint span, num, q;
    if (rng_max <= rng_min) return SCALE_ZERO;
    span = longint'(rng_max) - longint'(rng_min);
    num  = (longint'(h) - longint'(rng_min)) * 200 - 100 * span;
    q    = num / span;
    if (q > SCALE_POS) q = SCALE_POS;
    else if (q < SCALE_NEG) q = SCALE_NEG;
    else if (q < DEAD_HI && q > DEAD_LO) q = 0;
    return q[SCALE_W-1:0];
  endfunction

  function automatic norm_t normalize_pulse(logic [PW_W-1:0] pw);
    norm_t           r;
    logic [PW_W-1:0] pw_delta;
    r.accepted = (pw >= rng_min) && (pw <= rng_max);
    if (r.accepted) begin
      pw_delta = (pw > held_pw) ? pw - held_pw : held_pw - pw;
      if (pw_delta > HOLD_TOL) begin
        held_pw   = pw;
        held_flag = 1'b1;
      end else begin
        held_flag = 1'b0;
      end
    end
    r.changed    = held_flag;
    r.held_value = held_pw;
    r.scaled     = scale_of(held_pw);
    if (r.scaled > 0) r.direction = DIR_POS;
    else if (r.scaled < 0) r.direction = DIR_NEG;
    else r.direction = DIR_ZERO;
    r.switch_on  = bin_mode && (held_pw == rng_max);
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // input side driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_took) begin
    end else if (gap_left > 0) begin
      in_if.valid <= 1'b0;
      gap_left--;
    end else if (pulse_q.size() > 0) begin
      in_if.valid       <= 1'b1;
      in_if.pulse_width <= pulse_q.pop_front();
      if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 16);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // output side ready
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stalls_served != stall_requests) begin
      stalls_served++;
      hold_left = 300;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 15);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    in_took = rst_ni && in_if.valid && in_if.ready;
    if (in_took) norm_q.push_back(normalize_pulse(in_if.pulse_width));
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (norm_q.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = norm_q.pop_front();
        if (out_if.accepted !== want.accepted)
          flag_mismatch($sformatf("accepted %0d want %0d", out_if.accepted, want.accepted));
        if (out_if.changed !== want.changed)
          flag_mismatch($sformatf("changed %0d want %0d", out_if.changed, want.changed));
        if (out_if.held_value !== want.held_value)
          flag_mismatch($sformatf("held_value %0d want %0d", out_if.held_value,
                                  want.held_value));
        if (out_if.scaled !== want.scaled)
          flag_mismatch($sformatf("scaled %0d want %0d", out_if.scaled, want.scaled));
        if (out_if.direction !== want.direction)
          flag_mismatch($sformatf("direction %0d want %0d", out_if.direction,
                                  want.direction));
        if (out_if.switch_on !== want.switch_on)
          flag_mismatch($sformatf("switch_on %0d want %0d", out_if.switch_on,
                                  want.switch_on));
      end
    end
  end

  task automatic send_pulse(logic [PW_W-1:0] pw);
    pulse_q.push_back(pw);
    beats_queued++;
    last_pw = pw;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (results_seen < beats_queued);
    repeat (32) @(negedge clk_i);
  endtask

  task automatic program_range(logic [PW_W-1:0] lo, logic [PW_W-1:0] hi, logic bin);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RANGE_MIN;
    cfg_data_i <= lo;
    rng_min    = lo;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_RANGE_MAX;
    cfg_data_i <= hi;
    rng_max    = hi;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_BINARY_MODE;
    cfg_data_i <= {{(CFG_DATA_W-1){1'b0}}, bin};
    bin_mode   = bin;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [PW_W-1:0] pick_pulse();
    case ($urandom_range(0, 9))
      0, 1: return PW_W'($urandom_range(0, 65535));
      2: begin
        case ($urandom_range(0, 3))
          0: return rng_min;
          1: return rng_max;
          2: return PW_W'(rng_min - 1);
          default: return PW_W'(rng_max + 1);
        endcase
      end
      3: return PW_W'(last_pw + $urandom_range(0, 6) - 3);
      default: begin
        if (rng_max >= rng_min) return PW_W'($urandom_range(rng_max, rng_min));
        return PW_W'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  initial begin
    logic [PW_W-1:0] lo, hi;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_RANGE_MIN;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.pulse_width = '0;
    out_if.ready      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // held value starts outside the range
    program_range(16'd1000, 16'd2000, 1'b0);
    send_pulse(16'd0);
    send_pulse(16'd65535);
    send_pulse(16'd999);
    send_pulse(16'd1000);
    send_pulse(16'd2001);
    send_pulse(16'd2000);
    send_pulse(16'd1500);
    send_pulse(16'd1502);
    send_pulse(16'd1503);
    send_pulse(16'd1000);
    send_pulse(16'd1001);
    wait_drained();

    // dead zone edges and switch on
    program_range(16'd0, 16'd200, 1'b1);
    send_pulse(16'd91);
    send_pulse(16'd90);
    send_pulse(16'd109);
    send_pulse(16'd110);
    send_pulse(16'd200);
    send_pulse(16'd198);
    wait_drained();

    // empty range
    program_range(16'd500, 16'd500, 1'b0);
    send_pulse(16'd500);
    send_pulse(16'd499);
    send_pulse(16'd501);
    wait_drained();

    // inverted range
    program_range(16'd3000, 16'd100, 1'b1);
    send_pulse(16'd1000);
    send_pulse(16'd100);
    wait_drained();

    program_range(16'd0, 16'd65535, 1'b0);
    send_pulse(16'd0);
    send_pulse(16'd65535);
    send_pulse(16'd32767);
    send_pulse(16'd32768);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 6)
        0: begin
          lo = PW_W'($urandom_range(900, 1100));
          hi = PW_W'($urandom_range(1900, 2100));
        end
        1: begin
          lo = 16'd0;
          hi = 16'd65535;
        end
        2: begin
          lo = PW_W'($urandom_range(0, 65535));
          hi = PW_W'($urandom_range(0, 65535));
        end
        3: begin
          lo = PW_W'($urandom_range(0, 65000));
          hi = PW_W'(lo + $urandom_range(0, 20));
        end
        4: begin
          lo = PW_W'($urandom_range(0, 65535));
          hi = lo;
        end
        default: begin
          lo = PW_W'($urandom_range(0, 65535));
          hi = PW_W'($urandom_range(65535, lo));
        end
      endcase
      if (ph == 11) calm = 1'b1;
      program_range(lo, hi, 1'($urandom_range(0, 1)));
      repeat (165) send_pulse(pick_pulse());
      // long output stall while input keeps offering beats
      if (ph == 2 || ph == 7) stall_requests++;
      wait_drained();
    end

    if (norm_q.size() != 0) flag_mismatch("expected results left over");
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
